>>> hdl/rrts_pkg.sv
// shared widths, request codes and queue item types for the thread scheduler
package rrts_pkg;

  localparam int IDX_W   = 6;   // thread index, idle thread is zero
  localparam int CNT_W   = 6;   // thread_count register
  localparam int REQ_W   = 2;
  localparam int TICKS_W = 32;
  localparam int RB_W    = 32;  // ready_bits result field

  localparam int MAX_WORKERS_DEF   = 32;
  localparam int TIMEOUT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SCHED = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DELAY = 2'd1,
    CMD_SCHED = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [TICKS_W-1:0] ticks;
  } q_item_t;

endpackage

>>> hdl/rrts_ifs.sv
// valid/ready channel interfaces for requests, results and configuration
interface rrts_in_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [TICKS_W-1:0] delay_ticks;

  modport source (output valid, output req_type, output delay_ticks, input ready);
  modport sink   (input valid, input req_type, input delay_ticks, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] next_thread;
  logic             switch_needed;
  logic             delay_error;
  logic [RB_W-1:0]  ready_bits;

  modport source (output valid, output next_thread, output switch_needed,
                  output delay_error, output ready_bits, input ready);
  modport sink   (input valid, input next_thread, input switch_needed,
                  input delay_error, input ready_bits, output ready);
endinterface

interface rrts_cfg_if import rrts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] thread_count;

  modport source (output valid, output thread_count, input ready);
  modport sink   (input valid, input thread_count, output ready);
endinterface

>>> hdl/round_robin_thread_scheduler.sv
// top level of the round-robin thread scheduler with tick-driven delays
// Round-robin scheduler for an idle thread (index 0) and up to MAX_WORKERS
// worker threads. Requests arrive as transfers on in_ch: a tick counts every
// nonzero timeout of a registered worker down by one and makes a worker ready
// when its count reaches zero (no result); a delay loads the running worker's
// timeout, clears its ready bit and reschedules; a schedule request picks the
// next ready worker after the current one, wrapping to 1, or the idle thread
// when none is ready. Delays and schedule requests give one result transfer
// on out_ch; a delay while the idle thread runs, or before anything has run,
// is refused with delay_error set. Request code 3 is taken and ignored.
// In the execution unit a tick walks the timeout memory of the W registered
// workers one entry per cycle through its single read and write port, and a
// delay or schedule runs a round-robin search that tests one ready bit per
// cycle. A two-entry command queue sits between the front end and the
// execution unit, so requests are taken while earlier ones are still being
// worked on, and a finished result waits in its own output register. There
// is no clearing pass after reset: each timeout entry has a valid bit that
// reset clears. thread_count is written on cfg_ch and may only change while
// no request is in flight; it is taken in every cycle.
module round_robin_thread_scheduler import rrts_pkg::*; #(
  parameter int MAX_WORKERS   = MAX_WORKERS_DEF,
  parameter int TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rrts_in_if.sink     in_ch,
  rrts_out_if.source  out_ch,
  rrts_cfg_if.sink    cfg_ch
);

  // configuration register, one thread counts as registered after reset
  logic [CNT_W-1:0] thread_count_r;

  // front end to queue
  logic    f_valid, f_ready;
  q_item_t f_item;

  // queue to execution unit
  logic    q_valid, q_ready;
  q_item_t q_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thread_count_r <= CNT_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      thread_count_r <= cfg_ch.thread_count;
    end
  end

  // decode and hold one request
  rrts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  // decoupling queue
  rrts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // timeout walk, round-robin search, result register
  rrts_back #(
    .MAX_WORKERS   (MAX_WORKERS),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .thread_count (thread_count_r),
    .pop_valid    (q_valid),
    .pop_ready    (q_ready),
    .pop_item     (q_item),
    .out_ch       (out_ch)
  );

`ifndef SYNTHESIS
  // a refused delay never asks for a context switch
  a_err_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.delay_error) |-> !out_ch.switch_needed)
    else $error("refused delay reports a switch");

  // a chosen worker is always one of the ready workers
  a_pick_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.delay_error && (out_ch.next_thread != '0)) |->
    out_ch.ready_bits[5'(out_ch.next_thread - 6'd1)])
    else $error("scheduled worker is not ready");

  // the idle thread is chosen exactly when no worker is ready
  a_idle_iff_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.delay_error) |->
    ((out_ch.next_thread == '0) == (out_ch.ready_bits == '0)))
    else $error("idle choice does not match ready mask");

  // chosen index never exceeds the worker storage
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.next_thread <= IDX_W'(MAX_WORKERS)))
    else $error("next_thread out of range");
`endif

endmodule

>>> hdl/rrts_front.sv
// front end: accepts requests, decodes them and hands commands to the queue
module rrts_front import rrts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  rrts_in_if.sink in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output q_item_t push_item
);

  logic    hold_v_r, hold_v_nxt;
  q_item_t hold_r, hold_nxt;
  logic    accept;
  logic    dec_ok;
  cmd_t    dec_cmd;

  assign in_ch.ready = !hold_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_v_r;
  assign push_item   = hold_r;

  always_comb begin
    dec_ok  = 1'b1;
    dec_cmd = CMD_TICK;
    case (in_ch.req_type)
      REQ_TICK:  dec_cmd = CMD_TICK;
      REQ_DELAY: dec_cmd = CMD_DELAY;
      REQ_SCHED: dec_cmd = CMD_SCHED;
      default:   dec_ok  = 1'b0;  // unused code, dropped
    endcase
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (hold_v_r && push_ready) begin
      hold_v_nxt = 1'b0;
    end
    if (accept && dec_ok) begin
      hold_v_nxt     = 1'b1;
      hold_nxt.cmd   = dec_cmd;
      hold_nxt.ticks = in_ch.delay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

>>> hdl/rrts_queue.sv
// short command queue between the front end and the execution unit
module rrts_queue import rrts_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hdl/rrts_back.sv
// execution unit: timeout walk, round-robin search and result register
module rrts_back import rrts_pkg::*; #(
  parameter int MAX_WORKERS   = MAX_WORKERS_DEF,
  parameter int TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] thread_count,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  q_item_t          pop_item,
  rrts_out_if.source       out_ch
);

  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam logic [IDX_W-1:0] MAXW = IDX_W'(MAX_WORKERS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_TICK   = 4'b0010,
    S_SEARCH = 4'b0100,
    S_EMIT   = 4'b1000
  } bstate_t;

  bstate_t                  state_r, state_nxt;
  logic [MAX_WORKERS-1:0]   ready_r, ready_nxt;
  logic [MAX_WORKERS-1:0]   tvalid_r, tvalid_nxt;
  logic [IDX_W-1:0]         cur_r, cur_nxt;
  logic [IDX_W-1:0]         run_r, run_nxt;
  logic                     run_v_r, run_v_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     res_err_r, res_err_nxt;
  logic [IDX_W-1:0]         tick_n_r, tick_n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_next_r, out_next_nxt;
  logic                     out_sw_r, out_sw_nxt;
  logic                     out_err_r, out_err_nxt;
  logic [RB_W-1:0]          out_rb_r, out_rb_nxt;

  logic [TIMEOUT_WIDTH-1:0] mem [MAX_WORKERS];
  logic [TIMEOUT_WIDTH-1:0] rd_data_r;
  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [TIMEOUT_WIDTH-1:0] wr_data;

  logic [IDX_W-1:0]         wcnt_raw, wcnt, tc_lim, inc, cand, tick_inc;
  logic [MAX_WORKERS-1:0]   vmask, ready;
  logic [TIMEOUT_WIDTH-1:0] tval, tdec;
  logic                     run_ok;

  // registered workers, clamped to the storage size
  assign wcnt_raw = (thread_count == '0) ? '0 : thread_count - 1'b1;
  assign wcnt     = (wcnt_raw > MAXW) ? MAXW : wcnt_raw;
  assign tc_lim   = wcnt + 1'b1;

  always_comb begin
    for (int k = 0; k < MAX_WORKERS; k++) begin
      vmask[k] = (IDX_W'(k) < wcnt);
    end
  end

  assign ready    = ready_r & vmask;
  assign inc      = idx_r + 1'b1;
  assign cand     = (inc >= tc_lim) ? IDX_W'(1) : inc;
  assign tick_inc = tick_n_r + 1'b1;
  assign tval     = tvalid_r[tick_n_r[AW-1:0]] ? rd_data_r : '0;
  assign tdec     = tval - 1'b1;
  assign run_ok   = run_v_r && (run_r != '0) && (run_r <= MAXW);

  assign pop_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    tvalid_nxt    = tvalid_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    run_v_nxt     = run_v_r;
    idx_nxt       = idx_r;
    res_err_nxt   = res_err_r;
    tick_n_nxt    = tick_n_r;
    out_valid_nxt = out_valid_r;
    out_next_nxt  = out_next_r;
    out_sw_nxt    = out_sw_r;
    out_err_nxt   = out_err_r;
    out_rb_nxt    = out_rb_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          case (pop_item.cmd)
            CMD_TICK: begin
              if (wcnt != '0) begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                tick_n_nxt = '0;
                state_nxt  = S_TICK;
              end
            end
            CMD_DELAY: begin
              if (!run_ok) begin
                // refused: report the running thread, nothing changes
                res_err_nxt = 1'b1;
                idx_nxt     = run_r;
                state_nxt   = S_EMIT;
              end else begin
                wr_en               = 1'b1;
                wr_addr             = AW'(run_r - 1'b1);
                wr_data             = pop_item.ticks[TIMEOUT_WIDTH-1:0];
                tvalid_nxt[wr_addr] = 1'b1;
                ready_nxt[wr_addr]  = 1'b0;
                res_err_nxt         = 1'b0;
                idx_nxt             = cur_r;
                state_nxt           = S_SEARCH;
              end
            end
            CMD_SCHED: begin
              res_err_nxt = 1'b0;
              idx_nxt     = cur_r;
              state_nxt   = S_SEARCH;
            end
            default: ;
          endcase
        end
      end

      S_TICK: begin
        // read-modify-write, data of entry tick_n_r arrives this cycle
        if (tval != '0) begin
          wr_en                          = 1'b1;
          wr_addr                        = tick_n_r[AW-1:0];
          wr_data                        = tdec;
          tvalid_nxt[tick_n_r[AW-1:0]]   = 1'b1;
          if (tdec == '0) begin
            ready_nxt[tick_n_r[AW-1:0]] = 1'b1;
          end
        end
        if (tick_inc < wcnt) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(tick_inc);
          tick_n_nxt = tick_inc;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_SEARCH: begin
        if (ready == '0) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = cand;
          if (ready[AW'(cand - 1'b1)]) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_next_nxt  = idx_r;
          out_err_nxt   = res_err_r;
          out_sw_nxt    = !res_err_r && (!run_v_r || (run_r != idx_r));
          out_rb_nxt    = RB_W'(ready);
          if (!res_err_r) begin
            cur_nxt   = idx_r;
            run_nxt   = idx_r;
            run_v_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= '1;
      tvalid_r    <= '0;
      cur_r       <= '0;
      run_r       <= '0;
      run_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      tvalid_r    <= tvalid_nxt;
      cur_r       <= cur_nxt;
      run_r       <= run_nxt;
      run_v_r     <= run_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    res_err_r  <= res_err_nxt;
    tick_n_r   <= tick_n_nxt;
    out_next_r <= out_next_nxt;
    out_sw_r   <= out_sw_nxt;
    out_err_r  <= out_err_nxt;
    out_rb_r   <= out_rb_nxt;
  end

  // timeout store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_thread   = out_next_r;
  assign out_ch.switch_needed = out_sw_r;
  assign out_ch.delay_error   = out_err_r;
  assign out_ch.ready_bits    = out_rb_r;

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the round-robin thread scheduler
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  // request code that the block takes and drops without a result
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // cycles allowed for the command queue, the execution unit and the output
  // register to drain
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 160;

  // thread_count per random phase, the last one is drawn at random
  localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASES] = '{
    6'd33, 6'd2, 6'd17, 6'd1, 6'd63, 6'd0, 6'd32, 6'd5
  };
  // idling patterns: none, sender idle, receiver stalling, both
  localparam int IN_IDLE   [4] = '{0, 51, 0, 35};
  localparam int OUT_STALL [4] = '{0, 0, 51, 35};

  typedef struct packed {
    logic [IDX_W-1:0] next_thread;
    logic             switch_needed;
    logic             delay_error;
    logic [RB_W-1:0]  ready_bits;
  } sched_result_t;

  typedef struct packed {
    logic               cfg_write;   // write thread_count before this request
    logic [CNT_W-1:0]   cfg_value;
    logic [REQ_W-1:0]   code;
    logic [TICKS_W-1:0] ticks;
    logic               fixed;       // result typed in below, else predicted
    sched_result_t      want;
  } stim_row_t;

  localparam sched_result_t NO_RESULT = '{6'd0, 1'b0, 1'b0, 32'd0};

  // directed part: opening requests with no worker, the widest count,
  // delays of zero, one and the largest value, a cursor left past the count,
  // a refused delay by the idle thread, and the unused request code
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    // delay before any thread has run is refused
    '{1'b0, 6'd0,  REQ_DELAY,  32'd5,          1'b1, '{6'd0, 1'b0, 1'b1, 32'd0}},
    // first schedule with no workers picks idle and asks for a switch
    '{1'b0, 6'd0,  REQ_SCHED,  32'd0,          1'b1, '{6'd0, 1'b1, 1'b0, 32'd0}},
    // delay by the idle thread is refused
    '{1'b0, 6'd0,  REQ_DELAY,  32'hFFFF_FFFF,  1'b1, '{6'd0, 1'b0, 1'b1, 32'd0}},
    '{1'b0, 6'd0,  REQ_UNUSED, 32'hA5A5_A5A5,  1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_TICK,   32'd0,          1'b0, NO_RESULT},
    // all 32 workers registered, every one ready from reset
    '{1'b1, 6'd33, REQ_SCHED,  32'd0,          1'b1, '{6'd1, 1'b1, 1'b0, 32'hFFFF_FFFF}},
    // zero blocks thread 1 for good
    '{1'b0, 6'd0,  REQ_DELAY,  32'd0,          1'b1, '{6'd2, 1'b1, 1'b0, 32'hFFFF_FFFE}},
    '{1'b0, 6'd0,  REQ_DELAY,  32'hFFFF_FFFF,  1'b1, '{6'd3, 1'b1, 1'b0, 32'hFFFF_FFFC}},
    '{1'b0, 6'd0,  REQ_DELAY,  32'd1,          1'b1, '{6'd4, 1'b1, 1'b0, 32'hFFFF_FFF8}},
    // one tick wakes thread 3
    '{1'b0, 6'd0,  REQ_TICK,   32'h5A5A_5A5A,  1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_SCHED,  32'd0,          1'b1, '{6'd5, 1'b1, 1'b0, 32'hFFFF_FFFC}},
    // cursor at 5 with only three workers wraps back to 1
    '{1'b1, 6'd4,  REQ_SCHED,  32'd0,          1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_DELAY,  32'd2,          1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_TICK,   32'd0,          1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_TICK,   32'd0,          1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_SCHED,  32'd0,          1'b0, NO_RESULT},
    // same thread chosen again, no switch
    '{1'b0, 6'd0,  REQ_SCHED,  32'hFFFF_FFFF,  1'b0, NO_RESULT},
    // count of zero means no workers at all
    '{1'b1, 6'd0,  REQ_SCHED,  32'd0,          1'b1, '{6'd0, 1'b1, 1'b0, 32'd0}},
    '{1'b0, 6'd0,  REQ_DELAY,  32'd3,          1'b1, '{6'd0, 1'b0, 1'b1, 32'd0}},
    // count above the maximum acts as the maximum
    '{1'b1, 6'd63, REQ_SCHED,  32'd0,          1'b0, NO_RESULT},
    '{1'b1, 6'd2,  REQ_SCHED,  32'd0,          1'b0, NO_RESULT},
    '{1'b1, 6'd33, REQ_DELAY,  32'h8000_0000,  1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_SCHED,  32'd0,          1'b0, NO_RESULT},
    '{1'b0, 6'd0,  REQ_TICK,   32'hFFFF_FFFF,  1'b0, NO_RESULT}
  };

  logic clk;
  logic rst_n;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();
  rrts_cfg_if cfg_ch ();

  round_robin_thread_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the scheduler state
  logic [CNT_W-1:0]   sim_thread_count;
  logic [31:0]        sim_ready;
  logic [TICKS_W-1:0] sim_timeout [MAX_WORKERS_DEF];
  logic [IDX_W-1:0]   sim_cursor;
  logic [IDX_W-1:0]   sim_running;
  logic               sim_has_run;

  sched_result_t pending_results [$];
  int            error_count;
  int            in_idle_pct;
  int            out_stall_pct;
  bit            hold_off_req;

  // number of registered workers, capped at the maximum
  function automatic int worker_total();
    int w;
    w = (sim_thread_count >= 1) ? sim_thread_count - 1 : 0;
    return (w > MAX_WORKERS_DEF) ? MAX_WORKERS_DEF : w;
  endfunction

  function automatic logic [31:0] registered_mask();
    int w;
    w = worker_total();
    return (w == 0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - w));
  endfunction

  // round-robin pick after the cursor, wrapping to 1, idle when none is ready
  function automatic sched_result_t reschedule();
    sched_result_t res;
    logic [31:0]   ready;
    int            tc;
    int            idx;
    ready = sim_ready & registered_mask();
    tc    = worker_total() + 1;
    idx   = sim_cursor;
    if (ready == 32'd0) begin
      idx = 0;
    end else begin
      for (int g = 0; g < MAX_WORKERS_DEF + 2; g++) begin
        idx++;
        if (idx >= tc) idx = 1;
        if (ready[idx-1]) break;
      end
    end
    sim_cursor        = IDX_W'(idx);
    res.switch_needed = !sim_has_run || (sim_running != sim_cursor);
    sim_running       = sim_cursor;
    sim_has_run       = 1'b1;
    res.next_thread   = sim_cursor;
    res.delay_error   = 1'b0;
    res.ready_bits    = sim_ready & registered_mask();
    return res;
  endfunction

  // advances the shadow state by one request, returns 1 when a result is due
  function automatic bit apply_request(input logic [REQ_W-1:0] code,
                                       input logic [TICKS_W-1:0] ticks,
                                       output sched_result_t res);
    res = NO_RESULT;
    case (code)
      REQ_TICK: begin
        for (int n = 0; n < worker_total(); n++) begin
          if (sim_timeout[n] != '0) begin
            sim_timeout[n] = sim_timeout[n] - 1'b1;
            if (sim_timeout[n] == '0) sim_ready[n] = 1'b1;
          end
        end
        return 1'b0;
      end
      REQ_DELAY: begin
        if (!sim_has_run || sim_running == '0 || sim_running > MAX_WORKERS_DEF) begin
          res.next_thread   = sim_running;
          res.switch_needed = 1'b0;
          res.delay_error   = 1'b1;
          res.ready_bits    = sim_ready & registered_mask();
        end else begin
          sim_timeout[sim_running-1] = ticks;
          sim_ready[sim_running-1]   = 1'b0;
          res = reschedule();
        end
        return 1'b1;
      end
      REQ_SCHED: begin
        res = reschedule();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // one request transfer, with random idle cycles ahead of it; valid is left
  // high so that a following request goes out back to back
  task automatic transfer_request(input logic [REQ_W-1:0] code,
                                  input logic [TICKS_W-1:0] ticks,
                                  input logic fixed, input sched_result_t typed);
    sched_result_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= code;
    in_ch.delay_ticks <= ticks;
    do @(posedge clk); while (!in_ch.ready);
    if (apply_request(code, ticks, res)) pending_results.push_back(fixed ? typed : res);
  endtask

  // thread_count only changes with nothing in flight: results drained, then
  // a pause long enough for any trailing ticks to finish
  task automatic write_thread_count(input logic [CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.thread_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid     <= 1'b0;
    sim_thread_count = value;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, in case the block stops answering
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: checks each transfer against the oldest prediction and
  // drives ready, with random stalls and one long hold-off on request
  initial begin : result_checker
    int            hold;
    sched_result_t want;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual 0x%0h",
                   $time, out_ch.next_thread);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("next_thread", want.next_thread, out_ch.next_thread);
          compare_field("switch_needed", want.switch_needed, out_ch.switch_needed);
          compare_field("delay_error", want.delay_error, out_ch.delay_error);
          compare_field("ready_bits", want.ready_bits, out_ch.ready_bits);
        end
      end
      // long hold-off so the queue fills and the input side stalls
      if (hold_off_req) begin
        hold         = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // request side: reset, directed table, then random phases
  initial begin : stimulus
    logic [REQ_W-1:0]   code;
    logic [TICKS_W-1:0] ticks;
    logic [CNT_W-1:0]   count_value;
    int                 counted;
    int                 pick;

    error_count   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_off_req  = 1'b0;

    // shadow state as after reset
    sim_thread_count = 6'd1;
    sim_ready        = 32'hFFFF_FFFF;
    foreach (sim_timeout[i]) sim_timeout[i] = '0;
    sim_cursor  = '0;
    sim_running = '0;
    sim_has_run = 1'b0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_TICK;
    in_ch.delay_ticks   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.thread_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, typed-in results where they are plain to see
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].cfg_write) write_thread_count(DIRECTED_ROWS[i].cfg_value);
      transfer_request(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].ticks,
                       DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
    end

    // random phases, each with its own thread count and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      count_value = (p == PHASES - 1) ? CNT_W'($urandom_range(0, 63)) : PHASE_COUNTS[p];
      write_thread_count(count_value);
      in_idle_pct   = IN_IDLE[p % 4];
      out_stall_pct = OUT_STALL[p % 4];
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick  = $urandom_range(99);
        ticks = $urandom;
        if (pick < 35)      code = REQ_TICK;
        else if (pick < 62) code = REQ_DELAY;
        else if (pick < 96) code = REQ_SCHED;
        else                code = REQ_UNUSED;
        // short delays mostly, so ticks keep waking threads; now and then
        // a zero or a huge value that blocks the thread for the run
        if (code == REQ_DELAY) begin
          pick = $urandom_range(99);
          if (pick < 2)       ticks = '0;
          else if (pick < 98) ticks = $urandom_range(1, 6);
        end
        transfer_request(code, ticks, 1'b0, NO_RESULT);
        if (code != REQ_UNUSED) begin
          counted++;
          if (p == 0 && counted == 40) hold_off_req = 1'b1;
        end
      end
    end

    // drain, then a last quiet stretch for anything stray
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
